// ----- rtl/sfr_pkg.sv -----
// Shared types and constants for the status frame receiver.
// No dependencies; the config registers, parser, tracker, top level and testbench import this package.
`default_nettype none

package sfr_pkg;

    // Frame buffer geometry.
    localparam int HEAD_DEPTH = 7;
    localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);

    // Hard limit on the payload length, applied on top of the register.
    localparam logic [7:0] PAYLOAD_LIMIT = 8'd32;

    // Payload lengths that select the short and long status layouts.
    localparam logic [7:0] SHORT_MIN_LEN = 8'd4;
    localparam logic [7:0] LONG_MIN_LEN  = 8'd7;

    // Transaction commands.
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_GOTO = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    // Event codes.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_IGNORED = 3'd1;
    localparam logic [2:0] EV_STATUS  = 3'd2;
    localparam logic [2:0] EV_ACK     = 3'd3;
    localparam logic [2:0] EV_BADSUM  = 3'd4;
    localparam logic [2:0] EV_TOOLONG = 3'd5;

    // Command status codes.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RUNNING = 3'd1;
    localparam logic [2:0] ST_FAILED  = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_WAITING = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_TYPE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GOTO_TYPE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 3'd5;

    // Configuration register file contents.
    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] status_type_code;
        logic [7:0] ack_type_code;
        logic [7:0] goto_type_code;
        logic [7:0] max_payload_length;
    } cfg_t;

    // What the parser hands to the tracker for each byte.
    typedef struct packed {
        logic                           frame_ok;
        logic                           bad_sum;
        logic                           too_long;
        logic [7:0]                     frame_type;
        logic [7:0]                     frame_length;
        logic [HEAD_DEPTH-1:0][7:0]     head;
    } frame_t;

endpackage

`default_nettype wire

// ----- rtl/sfr_in_if.sv -----
// Input channel of the status frame receiver: valid, ready and one item.
// Depends on sfr_pkg for nothing but shares the house conventions.
`default_nettype none

interface sfr_in_if;

    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic [15:0] goto_angle;

    modport source (output valid, output command, output rx_byte, output goto_angle,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input goto_angle,
                    output ready);

endinterface

`default_nettype wire

// ----- rtl/sfr_out_if.sv -----
// Result channel of the status frame receiver: valid, ready and one result.
// Standalone; field widths follow the block's result format.
`default_nettype none

interface sfr_out_if;

    logic        valid;
    logic        ready;
    logic [2:0]  frame_event;
    logic [7:0]  rotor_state;
    logic [15:0] rotor_angle;
    logic [7:0]  rotor_errors;
    logic        rotor_executing;
    logic [15:0] rotor_target;
    logic        report_seen;
    logic [7:0]  ack_code_out;
    logic        tracking_active;
    logic [2:0]  command_status;

    modport source (output valid, output frame_event, output rotor_state,
                    output rotor_angle, output rotor_errors, output rotor_executing,
                    output rotor_target, output report_seen, output ack_code_out,
                    output tracking_active, output command_status, input ready);
    modport sink   (input valid, input frame_event, input rotor_state,
                    input rotor_angle, input rotor_errors, input rotor_executing,
                    input rotor_target, input report_seen, input ack_code_out,
                    input tracking_active, input command_status, output ready);

endinterface

`default_nettype wire

// ----- rtl/sfr_cfg_regs.sv -----
// Configuration register file of the status frame receiver.
// Depends on sfr_pkg for the register indexes and the cfg_t type.
`default_nettype none

module sfr_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    output sfr_pkg::cfg_t                      cfg
);
    import sfr_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first         <= 8'hAA;
            cfg_reg.sync_second        <= 8'h55;
            cfg_reg.status_type_code   <= 8'd2;
            cfg_reg.ack_type_code      <= 8'd6;
            cfg_reg.goto_type_code     <= 8'd4;
            cfg_reg.max_payload_length <= 8'd32;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  cfg_reg.sync_first         <= cfg_data;
                REG_SYNC_SECOND: cfg_reg.sync_second        <= cfg_data;
                REG_STATUS_TYPE: cfg_reg.status_type_code   <= cfg_data;
                REG_ACK_TYPE:    cfg_reg.ack_type_code      <= cfg_data;
                REG_GOTO_TYPE:   cfg_reg.goto_type_code     <= cfg_data;
                REG_MAX_LENGTH:  cfg_reg.max_payload_length <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/sfr_parser.sv -----
// Byte-serial frame parser: sync search, header capture, payload buffer
// and running XOR checksum. Depends on sfr_pkg for cfg_t and frame_t.
`default_nettype none

module sfr_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_en,
    input  wire logic [7:0]    rx_byte,
    input  wire sfr_pkg::cfg_t cfg,
    output sfr_pkg::frame_t    frame
);
    import sfr_pkg::*;

    // Parser phases.
    localparam logic [2:0] PH_SYNC1   = 3'd0;
    localparam logic [2:0] PH_SYNC2   = 3'd1;
    localparam logic [2:0] PH_TYPE    = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    logic [2:0]                 phase_reg, phase_next;
    logic [7:0]                 type_reg, type_next;
    logic [7:0]                 length_reg, length_next;
    logic [7:0]                 pos_reg, pos_next;
    logic [7:0]                 xor_reg, xor_next;
    logic [HEAD_DEPTH-1:0][7:0] head_reg, head_next;
    logic [7:0]                 pos_inc;

    assign pos_inc = pos_reg + 8'd1;

    // Next-state logic for one received byte.
    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        head_next   = head_reg;
        frame.frame_ok     = 1'b0;
        frame.bad_sum      = 1'b0;
        frame.too_long     = 1'b0;
        frame.frame_type   = type_reg;
        frame.frame_length = length_reg;
        frame.head         = head_reg;
        if (byte_en)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx_byte == cfg.sync_first)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == cfg.sync_second) ? PH_TYPE : PH_SYNC1;
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    xor_next   = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    length_next = rx_byte;
                    xor_next    = xor_reg ^ rx_byte;
                    pos_next    = 8'd0;
                    if (rx_byte > cfg.max_payload_length || rx_byte > PAYLOAD_LIMIT)
                    begin
                        frame.too_long = 1'b1;
                        phase_next     = PH_SYNC1;
                    end
                    else
                    begin
                        phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    // Only the head of the payload is kept; all of it is summed.
                    if (pos_reg < 8'(HEAD_DEPTH))
                        head_next[pos_reg[HEAD_IDX_W-1:0]] = rx_byte;
                    xor_next = xor_reg ^ rx_byte;
                    pos_next = pos_inc;
                    if (pos_inc >= length_reg)
                        phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    frame.frame_ok = (rx_byte == xor_reg);
                    frame.bad_sum  = (rx_byte != xor_reg);
                    phase_next     = PH_SYNC1;
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            type_reg   <= 8'd0;
            length_reg <= 8'd0;
            pos_reg    <= 8'd0;
            xor_reg    <= 8'd0;
            head_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            pos_reg    <= pos_next;
            xor_reg    <= xor_next;
            head_reg   <= head_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sfr_tracker.sv -----
// Remote state holder and goto tracker: decodes finished frames, handles
// goto and stop commands, derives the event and command status.
// Depends on sfr_pkg for cfg_t, frame_t and the code constants.
`default_nettype none

module sfr_tracker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire logic [1:0]      command,
    input  wire logic [15:0]     goto_angle,
    input  wire sfr_pkg::cfg_t   cfg,
    input  wire sfr_pkg::frame_t frame,
    output logic [2:0]           event_code,
    output logic [7:0]           held_state,
    output logic [15:0]          held_angle,
    output logic [7:0]           held_errors,
    output logic                 held_executing,
    output logic [15:0]          held_target,
    output logic                 held_valid,
    output logic [7:0]           held_ack,
    output logic                 pending_flag,
    output logic [2:0]           status_code
);
    import sfr_pkg::*;

    logic [7:0]  state_reg, state_next;
    logic [15:0] angle_reg, angle_next;
    logic [7:0]  errors_reg, errors_next;
    logic        exec_reg, exec_next;
    logic [15:0] target_reg, target_next;
    logic        valid_reg, valid_next;
    logic [7:0]  ack_reg, ack_next;
    logic        pend_reg, pend_next;
    logic [15:0] pend_target_reg, pend_target_next;
    logic        is_byte;

    assign is_byte = (command == CMD_BYTE);

    // Frame decode and command handling for one transaction.
    always_comb
    begin
        state_next       = state_reg;
        angle_next       = angle_reg;
        errors_next      = errors_reg;
        exec_next        = exec_reg;
        target_next      = target_reg;
        valid_next       = valid_reg;
        ack_next         = ack_reg;
        pend_next        = pend_reg;
        pend_target_next = pend_target_reg;
        event_code       = EV_NONE;
        if (step_en)
        begin
            priority if (is_byte && frame.too_long)
            begin
                event_code = EV_TOOLONG;
            end
            else if (is_byte && frame.bad_sum)
            begin
                event_code = EV_BADSUM;
            end
            else if (is_byte && frame.frame_ok)
            begin
                // Status wins when the status and ack codes are equal.
                priority if (frame.frame_type == cfg.status_type_code)
                begin
                    if (frame.frame_length < SHORT_MIN_LEN)
                    begin
                        event_code = EV_IGNORED;
                    end
                    else
                    begin
                        event_code  = EV_STATUS;
                        state_next  = frame.head[0];
                        angle_next  = {frame.head[2], frame.head[1]};
                        errors_next = frame.head[3];
                        if (frame.frame_length >= LONG_MIN_LEN)
                        begin
                            exec_next   = frame.head[4][0];
                            target_next = {frame.head[6], frame.head[5]};
                        end
                        else
                        begin
                            exec_next   = 1'b0;
                            target_next = {frame.head[2], frame.head[1]};
                        end
                        // A finished or failed move ends tracking.
                        if (pend_reg && !exec_next &&
                            (errors_next != 8'd0 || angle_next == pend_target_reg))
                            pend_next = 1'b0;
                        valid_next = 1'b1;
                    end
                end
                else if (frame.frame_type == cfg.ack_type_code)
                begin
                    if (frame.frame_length == 8'd0)
                    begin
                        event_code = EV_IGNORED;
                    end
                    else
                    begin
                        event_code = EV_ACK;
                        ack_next   = frame.head[0];
                        if (frame.head[0] == cfg.goto_type_code)
                            pend_next = 1'b1;
                    end
                end
                else
                begin
                    event_code = EV_IGNORED;
                end
            end
            else if (command == CMD_GOTO)
            begin
                pend_target_next = goto_angle;
                pend_next        = 1'b0;
            end
            else if (command == CMD_STOP)
            begin
                pend_next        = 1'b0;
                pend_target_next = angle_reg;
            end
            else
            begin
                event_code = EV_NONE;
            end
        end
    end

    // Held remote state and tracking registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= 8'd0;
            angle_reg       <= 16'd0;
            errors_reg      <= 8'd0;
            exec_reg        <= 1'b0;
            target_reg      <= 16'd0;
            valid_reg       <= 1'b0;
            ack_reg         <= 8'd0;
            pend_reg        <= 1'b0;
            pend_target_reg <= 16'd0;
        end
        else
        begin
            state_reg       <= state_next;
            angle_reg       <= angle_next;
            errors_reg      <= errors_next;
            exec_reg        <= exec_next;
            target_reg      <= target_next;
            valid_reg       <= valid_next;
            ack_reg         <= ack_next;
            pend_reg        <= pend_next;
            pend_target_reg <= pend_target_next;
        end
    end

    // Command status from the held values; first match wins.
    always_comb
    begin
        priority if (!pend_reg)
            status_code = ST_IDLE;
        else if (exec_reg)
            status_code = ST_RUNNING;
        else if (errors_reg != 8'd0)
            status_code = ST_FAILED;
        else if (valid_reg && angle_reg == pend_target_reg)
            status_code = ST_DONE;
        else
            status_code = ST_WAITING;
    end

    assign held_state     = state_reg;
    assign held_angle     = angle_reg;
    assign held_errors    = errors_reg;
    assign held_executing = exec_reg;
    assign held_target    = target_reg;
    assign held_valid     = valid_reg;
    assign held_ack       = ack_reg;
    assign pending_flag   = pend_reg;

endmodule

`default_nettype wire

// ----- rtl/status_frame_receiver.sv -----
// Top level of the status frame receiver: input register, parser, tracker
// and result register. Depends on sfr_pkg, sfr_in_if, sfr_out_if,
// sfr_cfg_regs, sfr_parser and sfr_tracker.
`default_nettype none

// Parses frames of sync1, sync2, type, length, payload and an XOR checksum
// from a stream of transactions that carry either a received byte or a
// locally issued goto or stop, and returns one result per transaction: an
// event code, the last reported remote state, angle, errors, executing flag
// and target, and the derived goto command status. Each transaction passes
// through the input register, then the result register, and the block
// accepts one transaction every cycle while the result side is not stalled.
// Configuration is to be written through cfg_wr_en, cfg_index and cfg_data
// only while no transaction is in flight; the block does not enforce this.

module status_frame_receiver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    sfr_in_if.sink                             in_ch,
    sfr_out_if.source                          out_ch,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);
    import sfr_pkg::*;

    cfg_t        cfg;
    frame_t      frame;
    logic        in_valid_reg;
    logic [1:0]  command_reg;
    logic [7:0]  rx_byte_reg;
    logic [15:0] goto_angle_reg;
    logic        out_valid_reg;
    logic [2:0]  event_reg;
    logic [2:0]  event_code;
    logic        step_fire;
    logic        byte_en;

    // The held item is processed when the result register is free or drains.
    assign step_fire   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || step_fire;
    assign byte_en     = step_fire && (command_reg == CMD_BYTE);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            command_reg    <= in_ch.command;
            rx_byte_reg    <= in_ch.rx_byte;
            goto_angle_reg <= in_ch.goto_angle;
        end
    end

    sfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (rx_byte_reg),
        .cfg     (cfg),
        .frame   (frame)
    );

    sfr_tracker u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_fire),
        .command        (command_reg),
        .goto_angle     (goto_angle_reg),
        .cfg            (cfg),
        .frame          (frame),
        .event_code     (event_code),
        .held_state     (out_ch.rotor_state),
        .held_angle     (out_ch.rotor_angle),
        .held_errors    (out_ch.rotor_errors),
        .held_executing (out_ch.rotor_executing),
        .held_target    (out_ch.rotor_target),
        .held_valid     (out_ch.report_seen),
        .held_ack       (out_ch.ack_code_out),
        .pending_flag   (out_ch.tracking_active),
        .status_code    (out_ch.command_status)
    );

    // Result register. The held values only change on a processed item, so
    // they stay in step with the pending result while it waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
            event_reg <= event_code;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.frame_event = event_reg;

    // A processed item always leaves a result behind it.
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> out_valid_reg)
        else $error("processed transaction left no result");

    // A held item that cannot be processed stays held.
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step_fire |=> in_valid_reg)
        else $error("held transaction dropped");

    // Without tracking the command status is idle.
    a_idle_status: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.tracking_active |-> out_ch.command_status == ST_IDLE)
        else $error("command status not idle while not tracking");

    // A stalled result keeps its event code until it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> $stable(event_reg))
        else $error("waiting result changed");

endmodule

`default_nettype wire

// ----- dv/status_frame_receiver_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for status_frame_receiver: sends byte, goto and stop transactions,
// predicts every result with a local model of the frame parser and goto tracker, and compares.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if and the RTL of the block.

module status_frame_receiver_tb;
    import sfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASE_ITEMS   = 330;

    // The one command value that the package leaves unnamed; the block ignores it.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Register values after reset.
    localparam logic [7:0] DEF_SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] DEF_SYNC_SECOND = 8'h55;
    localparam logic [7:0] DEF_STATUS_TYPE = 8'h02;
    localparam logic [7:0] DEF_ACK_TYPE    = 8'h06;
    localparam logic [7:0] DEF_GOTO_TYPE   = 8'h04;
    localparam logic [7:0] DEF_MAX_LENGTH  = 8'd32;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK
    } rx_phase_e;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [2:0]  frame_event;
        logic [7:0]  rotor_state;
        logic [15:0] rotor_angle;
        logic [7:0]  rotor_errors;
        logic        rotor_executing;
        logic [15:0] rotor_target;
        logic        report_seen;
        logic [7:0]  ack_code_out;
        logic        tracking_active;
        logic [2:0]  command_status;
    } rotor_report_t;

    // One row of the opening script; a pinned row also carries its known event.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  rx;
        logic [15:0] ang;
        logic        pinned;
        logic [2:0]  pinned_event;
    } opening_row_t;

    localparam int OPENING_ROWS = 27;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    sfr_in_if  rx_link();
    sfr_out_if report_link();

    status_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (rx_link),
        .out_ch    (report_link),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Settings copy and parser state of the local model.
    cfg_t        cfg;
    rx_phase_e   parse_phase;
    logic [7:0]  frm_type;
    logic [7:0]  frm_len;
    logic [7:0]  frm_pos;
    logic [7:0]  frm_xor;
    logic [7:0]  frm_head [HEAD_DEPTH];

    // Remote view and goto tracking of the local model.
    logic [7:0]  rem_state;
    logic [7:0]  rem_errors;
    logic [7:0]  rem_ack;
    logic [15:0] rem_angle;
    logic [15:0] rem_target;
    logic        rem_exec;
    logic        rem_seen;
    logic        goto_tracking;
    logic [15:0] goto_target;

    rotor_report_t expected_reports [$];

    // Bookkeeping shared by the driver and the monitor.
    int unsigned src_idle_pct  = 6;
    int unsigned sink_idle_pct = 51;
    int unsigned taken_count   = 0;
    int unsigned sent_count    = 0;
    int unsigned result_count  = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned event_tally [8];
    logic        drv_pinned       = 1'b0;
    logic [2:0]  drv_pinned_event = EV_NONE;
    logic [15:0] aim_angle        = 16'h0000;

    opening_row_t opening_rows [OPENING_ROWS] = '{
        // Goto to the largest angle.
        '{CMD_GOTO, 8'h00, 16'hFFFF, 1'b1, EV_NONE},
        // Acknowledge that names the goto code, which arms tracking.
        '{CMD_BYTE, DEF_SYNC_FIRST,  16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, DEF_SYNC_SECOND, 16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, DEF_ACK_TYPE,    16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'h01,           16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, DEF_GOTO_TYPE,   16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'h03,           16'h0000, 1'b1, EV_ACK},
        // Short status frame at the goto angle, which ends tracking.
        '{CMD_BYTE, DEF_SYNC_FIRST,  16'hFFFF, 1'b0, EV_NONE},
        '{CMD_BYTE, DEF_SYNC_SECOND, 16'hFFFF, 1'b0, EV_NONE},
        '{CMD_BYTE, DEF_STATUS_TYPE, 16'hFFFF, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'h04,           16'hFFFF, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'h11,           16'hFFFF, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'hFF,           16'hFFFF, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'hFF,           16'hFFFF, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'h00,           16'hFFFF, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'h17,           16'hFFFF, 1'b1, EV_STATUS},
        // The largest length byte aborts the frame.
        '{CMD_BYTE, DEF_SYNC_FIRST,  16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, DEF_SYNC_SECOND, 16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, DEF_STATUS_TYPE, 16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'hFF,           16'h0000, 1'b1, EV_TOOLONG},
        // Empty acknowledge with a wrong checksum.
        '{CMD_BYTE, DEF_SYNC_FIRST,  16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, DEF_SYNC_SECOND, 16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, DEF_ACK_TYPE,    16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'h00,           16'h0000, 1'b0, EV_NONE},
        '{CMD_BYTE, 8'h07,           16'h0000, 1'b1, EV_BADSUM},
        // Stop and the unused command value.
        '{CMD_STOP,  8'h00, 16'h0000, 1'b1, EV_NONE},
        '{CMD_SPARE, 8'hFF, 16'hFFFF, 1'b1, EV_NONE}
    };

    // Puts the local model into its state after reset.
    task automatic reset_model();
        cfg = '{DEF_SYNC_FIRST, DEF_SYNC_SECOND, DEF_STATUS_TYPE, DEF_ACK_TYPE,
                DEF_GOTO_TYPE, DEF_MAX_LENGTH};
        parse_phase = PH_SYNC1;
        frm_type = 8'h00;
        frm_len = 8'h00;
        frm_pos = 8'h00;
        frm_xor = 8'h00;
        foreach (frm_head[i])
            frm_head[i] = 8'h00;
        rem_state = 8'h00;
        rem_errors = 8'h00;
        rem_ack = 8'h00;
        rem_angle = 16'h0000;
        rem_target = 16'h0000;
        rem_exec = 1'b0;
        rem_seen = 1'b0;
        goto_tracking = 1'b0;
        goto_target = 16'h0000;
    endtask

    // Acts on a frame whose checksum matched and returns its event.
    function automatic logic [2:0] take_frame();
        if (frm_type == cfg.status_type_code)
        begin
            if (frm_len < SHORT_MIN_LEN)
                return EV_IGNORED;
            rem_state = frm_head[0];
            rem_angle = {frm_head[2], frm_head[1]};
            rem_errors = frm_head[3];
            if (frm_len >= LONG_MIN_LEN)
            begin
                rem_exec = frm_head[4][0];
                rem_target = {frm_head[6], frm_head[5]};
            end
            else
            begin
                rem_exec = 1'b0;
                rem_target = rem_angle;
            end
            // A finished move ends tracking, with or without success.
            if (goto_tracking && !rem_exec && (rem_errors != 8'h00 || rem_angle == goto_target))
                goto_tracking = 1'b0;
            rem_seen = 1'b1;
            return EV_STATUS;
        end
        if (frm_type == cfg.ack_type_code)
        begin
            if (frm_len == 8'h00)
                return EV_IGNORED;
            rem_ack = frm_head[0];
            if (rem_ack == cfg.goto_type_code)
                goto_tracking = 1'b1;
            return EV_ACK;
        end
        return EV_IGNORED;
    endfunction

    // Advances the local model by one accepted transaction and returns its result.
    function automatic rotor_report_t predict_report(input logic [1:0] cmd, input logic [7:0] rx,
                                                      input logic [15:0] ang);
        rotor_report_t r;
        logic [2:0] ev;
        ev = EV_NONE;
        if (cmd == CMD_BYTE)
        begin
            case (parse_phase)
                PH_SYNC1:
                    if (rx == cfg.sync_first)
                        parse_phase = PH_SYNC2;
                PH_SYNC2:
                    parse_phase = (rx == cfg.sync_second) ? PH_TYPE : PH_SYNC1;
                PH_TYPE:
                begin
                    frm_type = rx;
                    frm_xor = rx;
                    parse_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    frm_len = rx;
                    frm_xor = frm_xor ^ rx;
                    frm_pos = 8'h00;
                    if (rx > cfg.max_payload_length || rx > PAYLOAD_LIMIT)
                    begin
                        ev = EV_TOOLONG;
                        parse_phase = PH_SYNC1;
                    end
                    else
                        parse_phase = (rx == 8'h00) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    // Only the head of the payload is kept; the rest only enters the sum.
                    if (int'(frm_pos) < HEAD_DEPTH)
                        frm_head[frm_pos[2:0]] = rx;
                    frm_xor = frm_xor ^ rx;
                    frm_pos = frm_pos + 8'd1;
                    if (frm_pos >= frm_len)
                        parse_phase = PH_CHECK;
                end
                PH_CHECK:
                begin
                    ev = (rx == frm_xor) ? take_frame() : EV_BADSUM;
                    parse_phase = PH_SYNC1;
                end
                default:
                    parse_phase = PH_SYNC1;
            endcase
        end
        else if (cmd == CMD_GOTO)
        begin
            goto_target = ang;
            goto_tracking = 1'b0;
        end
        else if (cmd == CMD_STOP)
        begin
            goto_tracking = 1'b0;
            goto_target = rem_angle;
        end

        r.frame_event = ev;
        r.rotor_state = rem_state;
        r.rotor_angle = rem_angle;
        r.rotor_errors = rem_errors;
        r.rotor_executing = rem_exec;
        r.rotor_target = rem_target;
        r.report_seen = rem_seen;
        r.ack_code_out = rem_ack;
        r.tracking_active = goto_tracking;
        // First matching condition gives the command status.
        if (!goto_tracking)
            r.command_status = ST_IDLE;
        else if (rem_exec)
            r.command_status = ST_RUNNING;
        else if (rem_errors != 8'h00)
            r.command_status = ST_FAILED;
        else if (rem_seen && rem_angle == goto_target)
            r.command_status = ST_DONE;
        else
            r.command_status = ST_WAITING;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        end
    endfunction

    // Cycle limit guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Cycle limit reached with %0d results outstanding.",
                     expected_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver side: ready drops at random for the current share of cycles.
    always @(negedge clk)
        report_link.ready = ($urandom_range(99) >= sink_idle_pct);

    // Accepted transactions feed the model; returned results are checked in order.
    always @(posedge clk)
    begin : watch_links
        rotor_report_t want;
        if (rst_n && rx_link.valid && rx_link.ready)
        begin
            want = predict_report(rx_link.command, rx_link.rx_byte, rx_link.goto_angle);
            if (drv_pinned)
                want.frame_event = drv_pinned_event;
            expected_reports.push_back(want);
            taken_count++;
        end
        if (rst_n && report_link.valid && report_link.ready)
        begin
            result_count++;
            event_tally[report_link.frame_event]++;
            if (expected_reports.size() == 0)
            begin
                error_count++;
                $error("result transaction arrived with no expectation waiting");
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("frame_event", 16'(want.frame_event), 16'(report_link.frame_event));
                check_field("rotor_state", 16'(want.rotor_state), 16'(report_link.rotor_state));
                check_field("rotor_angle", want.rotor_angle, report_link.rotor_angle);
                check_field("rotor_errors", 16'(want.rotor_errors),
                            16'(report_link.rotor_errors));
                check_field("rotor_executing", 16'(want.rotor_executing),
                            16'(report_link.rotor_executing));
                check_field("rotor_target", want.rotor_target, report_link.rotor_target);
                check_field("report_seen", 16'(want.report_seen), 16'(report_link.report_seen));
                check_field("ack_code_out", 16'(want.ack_code_out),
                            16'(report_link.ack_code_out));
                check_field("tracking_active", 16'(want.tracking_active),
                            16'(report_link.tracking_active));
                check_field("command_status", 16'(want.command_status),
                            16'(report_link.command_status));
            end
        end
    end

    // Sends one transaction, with random idle cycles ahead of it. Called at a falling edge.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] rx, input logic [15:0] ang,
                             input logic pin, input logic [2:0] pin_ev);
        int unsigned mark;
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_link.valid = 1'b0;
            rx_link.command = 2'($urandom);
            rx_link.rx_byte = 8'($urandom);
            rx_link.goto_angle = 16'($urandom);
            @(negedge clk);
        end
        rx_link.valid = 1'b1;
        rx_link.command = cmd;
        rx_link.rx_byte = rx;
        rx_link.goto_angle = ang;
        drv_pinned = pin;
        drv_pinned_event = pin_ev;
        mark = taken_count;
        do
            @(negedge clk);
        while (taken_count == mark);
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(CMD_BYTE, b, 16'($urandom), 1'b0, EV_NONE);
    endtask

    // Holds the sender until every expected result is back and the block has settled.
    task automatic drain_results();
        rx_link.valid = 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_SYNC_FIRST:  cfg.sync_first = val;
            REG_SYNC_SECOND: cfg.sync_second = val;
            REG_STATUS_TYPE: cfg.status_type_code = val;
            REG_ACK_TYPE:    cfg.ack_type_code = val;
            REG_GOTO_TYPE:   cfg.goto_type_code = val;
            REG_MAX_LENGTH:  cfg.max_payload_length = val;
            default:         ;
        endcase
    endtask

    // Rewrites every register once the block is idle.
    task automatic load_settings(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] st,
                                 input logic [7:0] ak, input logic [7:0] gt, input logic [7:0] mx);
        drain_results();
        write_reg(REG_SYNC_FIRST, s1);
        write_reg(REG_SYNC_SECOND, s2);
        write_reg(REG_STATUS_TYPE, st);
        write_reg(REG_ACK_TYPE, ak);
        write_reg(REG_GOTO_TYPE, gt);
        write_reg(REG_MAX_LENGTH, mx);
    endtask

    // Sends one frame with random content under the current settings. A cut frame
    // stops partway through its payload, so the next bytes get swallowed by it.
    task automatic send_frame(input bit cut_short);
        logic [7:0] ftype;
        logic [7:0] flen;
        logic [7:0] fsum;
        logic [7:0] body [$];
        int unsigned lim;
        int unsigned roll;
        int unsigned keep;
        roll = $urandom_range(99);
        if (roll < 55)
            ftype = cfg.status_type_code;
        else if (roll < 85)
            ftype = cfg.ack_type_code;
        else
            ftype = 8'($urandom);
        lim = (cfg.max_payload_length < PAYLOAD_LIMIT) ? cfg.max_payload_length
                                                        : PAYLOAD_LIMIT;
        // Mostly short payloads, some up to the limit and a few beyond it.
        roll = $urandom_range(99);
        if (roll < 6 && !cut_short)
            flen = 8'($urandom_range(255, lim + 1));
        else if (roll < 14)
            flen = 8'($urandom_range(lim, 0));
        else
            flen = 8'($urandom_range((lim < 9) ? lim : 9, 0));
        if (flen <= lim)
            for (int i = 0; i < flen; i++)
                body.push_back(8'($urandom));

        // Steer content toward the tracking outcomes.
        if (ftype == cfg.status_type_code && body.size() >= 4)
        begin
            if ($urandom_range(99) < 45)
            begin
                body[1] = aim_angle[7:0];
                body[2] = aim_angle[15:8];
            end
            if ($urandom_range(99) < 75)
                body[3] = 8'h00;
        end
        else if (ftype == cfg.ack_type_code && body.size() >= 1 && $urandom_range(99) < 60)
            body[0] = cfg.goto_type_code;

        fsum = ftype ^ flen;
        foreach (body[i])
            fsum = fsum ^ body[i];
        if ($urandom_range(99) < 12)
            fsum = fsum ^ 8'($urandom_range(255, 1));

        send_byte(cfg.sync_first);
        send_byte(cfg.sync_second);
        send_byte(ftype);
        send_byte(flen);
        if (flen <= lim)
        begin
            keep = (cut_short && flen != 8'h00) ? $urandom_range(flen - 1, 0) : flen;
            for (int i = 0; i < keep; i++)
                send_byte(body[i]);
            if (!cut_short)
                send_byte(fsum);
        end
    endtask

    // Mostly well-formed frames, with goto, stop, noise and cut frames mixed in.
    task automatic send_random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned roll;
        logic [15:0] ang;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 66)
                send_frame(1'b0);
            else if (roll < 72)
                send_frame(1'b1);
            else if (roll < 80)
            begin
                ang = 16'($urandom);
                aim_angle = ang;
                send_item(CMD_GOTO, 8'($urandom), ang, 1'b0, EV_NONE);
            end
            else if (roll < 85)
                send_item(CMD_STOP, 8'($urandom), 16'($urandom), 1'b0, EV_NONE);
            else if (roll < 88)
                send_item(CMD_SPARE, 8'($urandom), 16'($urandom), 1'b0, EV_NONE);
            else if (roll < 99)
            begin
                if ($urandom_range(1) == 1)
                    send_byte(cfg.sync_first);
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
            end
            else
                drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        rx_link.valid = 1'b0;
        rx_link.command = CMD_BYTE;
        rx_link.rx_byte = 8'h00;
        rx_link.goto_angle = 16'h0000;
        report_link.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SYNC_FIRST;
        cfg_data = 8'h00;
        foreach (event_tally[i])
            event_tally[i] = 0;
        reset_model();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Sender seldom idles, receiver stalls about half the time.
        src_idle_pct = 6;
        sink_idle_pct = 51;
        foreach (opening_rows[i])
            send_item(opening_rows[i].cmd, opening_rows[i].rx, opening_rows[i].ang,
                      opening_rows[i].pinned, opening_rows[i].pinned_event);
        send_random_traffic(PHASE_ITEMS);
        // Low extremes: zero maximum length leaves only empty payloads.
        load_settings(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_random_traffic(PHASE_ITEMS / 2);

        // Sender idles about half the time, receiver seldom stalls.
        src_idle_pct = 51;
        sink_idle_pct = 6;
        // Status and ack share one code, and the register is above the hard limit.
        load_settings(8'hFF, 8'h00, 8'h5A, 8'h5A, 8'h00, 8'hFF);
        send_random_traffic(PHASE_ITEMS);
        // Short status form only.
        load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'd6);
        send_random_traffic(PHASE_ITEMS);

        // Back to back in both directions.
        src_idle_pct = 0;
        sink_idle_pct = 0;
        load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), LONG_MIN_LEN);
        send_random_traffic(PHASE_ITEMS);
        load_settings(DEF_SYNC_FIRST, DEF_SYNC_SECOND, DEF_STATUS_TYPE, DEF_ACK_TYPE,
                      DEF_GOTO_TYPE, DEF_MAX_LENGTH);
        send_random_traffic(PHASE_ITEMS);

        drain_results();
        $display("Checked %0d results from %0d transactions over six register settings.",
                 result_count, sent_count);
        $display("Events: %0d status, %0d ack, %0d bad sum, %0d too long, %0d ignored.",
                 event_tally[EV_STATUS], event_tally[EV_ACK], event_tally[EV_BADSUM],
                 event_tally[EV_TOOLONG], event_tally[EV_IGNORED]);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sfr_pkg.sv
rtl/sfr_in_if.sv
rtl/sfr_out_if.sv
rtl/sfr_cfg_regs.sv
rtl/sfr_parser.sv
rtl/sfr_tracker.sv
rtl/status_frame_receiver.sv
dv/status_frame_receiver_tb.sv
